// File: src/clfe_pkg.sv
// Shared types, constants and elaboration-time functions for calo_layers_from_edge.
// Holds the side-normal sine/cosine generator and the inter-stage structs.
// No dependencies.
package clfe_pkg;

    // Geometry build options
    localparam int BARREL_SIDES       = 8;
    localparam int ENDCAP_SIDES       = 8;
    localparam int BARREL_PHASE_STEPS = 0;
    localparam int ENDCAP_PHASE_STEPS = 0;

    // Max-projection tree: leaves padded to a power of two
    localparam int MAX_SIDES   = 32;
    localparam int TREE_LEVELS = $clog2(MAX_SIDES);
    localparam int TREE_NODES  = 2 * MAX_SIDES - 1;

    // Radius unit latencies
    localparam int  POLY_LAT    = TREE_LEVELS + 2;
    localparam int  SQRT_STEPS  = 26;
    localparam int  SQRT_LAT    = SQRT_STEPS + 2;
    localparam bit  ANY_SQRT    = (BARREL_SIDES <= 2) || (ENDCAP_SIDES <= 2);
    localparam int  RAD_LAT     = ANY_SQRT ? SQRT_LAT : POLY_LAT;
    localparam int  FRONT_LAT   = RAD_LAT + 1;

    // Data widths
    localparam int COORD_W = 18;
    localparam int CFG_W   = 17;
    localparam int MRL_W   = 16;
    localparam int RAD_W   = 26;
    localparam int NUM_W   = 28;
    localparam int MAG_W   = NUM_W - 1;
    localparam int DEN_W   = CFG_W + 4;
    localparam int OUT_W   = 16;

    // Divider and back end
    localparam int DIV_STAGES = MAG_W;
    localparam int BACK_LAT   = DIV_STAGES + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPLIT_Z          = 8'd0,
        CFG_BARREL_OUTER_R   = 8'd1,
        CFG_ENDCAP_OUTER_R   = 8'd2,
        CFG_ENDCAP_OUTER_Z   = 8'd3,
        CFG_BARREL_OUTER_Z   = 8'd4,
        CFG_BARREL_THICK     = 8'd5,
        CFG_ENDCAP_THICK     = 8'd6,
        CFG_MAX_REAR_LAYERS  = 8'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] split_z;
        logic [CFG_W-1:0] barrel_outer_radius;
        logic [CFG_W-1:0] endcap_outer_radius;
        logic [CFG_W-1:0] endcap_outer_z;
        logic [CFG_W-1:0] barrel_outer_z;
        logic [CFG_W-1:0] barrel_layer_thickness;
        logic [CFG_W-1:0] endcap_layer_thickness;
        logic [MRL_W-1:0] max_rear_layers;
    } cfg_t;

    // One classified hit: three division jobs plus the region flag
    typedef struct packed {
        logic signed [NUM_W-1:0] num_a;
        logic [DEN_W-1:0]        den_a;
        logic signed [NUM_W-1:0] num_b;
        logic [DEN_W-1:0]        den_b;
        logic signed [NUM_W-1:0] num_c;
        logic [DEN_W-1:0]        den_c;
        logic                    barrel;
    } q_entry_t;

    // Quarter-wave sine polynomial, Q30 coefficients
    localparam longint unsigned SIN_C1  = 64'd1686629713;
    localparam longint unsigned SIN_C3  = 64'd693598667;
    localparam longint unsigned SIN_C5  = 64'd85569300;
    localparam longint unsigned SIN_C7  = 64'd5026990;
    localparam longint unsigned SIN_C9  = 64'd172276;
    localparam longint unsigned QUARTER = 64'd262144;

    function automatic longint unsigned quarter_sine(longint unsigned r);
        longint unsigned u2;
        longint unsigned t;
        u2 = (r * r) >> 18;
        t  = SIN_C9;
        t  = SIN_C7 - ((t * u2) >> 18);
        t  = SIN_C5 - ((t * u2) >> 18);
        t  = SIN_C3 - ((t * u2) >> 18);
        t  = SIN_C1 - ((t * u2) >> 18);
        t  = (t * r) >> 18;
        return (t + 64'd16384) >> 15;
    endfunction

    // Normal angle in 2^-20 turn
    function automatic longint unsigned angle_barrel(int i);
        longint unsigned a;
        a = (longint'(BARREL_PHASE_STEPS & 1023) << 10)
          + ((((longint'(i) << 21) / BARREL_SIDES) + 1) >> 1);
        return a & 64'hFFFFF;
    endfunction

    function automatic longint unsigned angle_endcap(int i);
        longint unsigned a;
        a = (longint'(ENDCAP_PHASE_STEPS & 1023) << 10)
          + ((((longint'(i) << 21) / ENDCAP_SIDES) + 1) >> 1);
        return a & 64'hFFFFF;
    endfunction

    // Q15 sine (want_sin) or cosine of an angle
    function automatic logic signed [16:0] norm_val(longint unsigned a, bit want_sin);
        longint unsigned q;
        longint unsigned r;
        longint          sr;
        longint          cr;
        longint          s;
        longint          c;
        q  = (a >> 18) & 64'd3;
        r  = a & (QUARTER - 64'd1);
        sr = longint'(quarter_sine(r));
        cr = longint'(quarter_sine(QUARTER - r));
        case (q)
            64'd0:   begin s = sr;  c = cr;  end
            64'd1:   begin s = cr;  c = -sr; end
            64'd2:   begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr;  end
        endcase
        return want_sin ? 17'(s) : 17'(c);
    endfunction

    function automatic int poly_sides(int p);
        return (p == 0) ? BARREL_SIDES : ENDCAP_SIDES;
    endfunction

endpackage

// File: src/calo_layers_from_edge.sv
// Top level of calo_layers_from_edge: configuration registers, front, queue, back.
// Depends on clfe_pkg, clfe_front, clfe_queue, clfe_back.
//
// Takes one hit per clock while full is low and returns, in order, the number
// of whole layers between the hit and the nearest outer calorimeter edge. Hits
// enter through push/full and results leave through empty/pop. Throughput is
// one hit per cycle while results are popped and the queue does not fill. A hit
// passes through the radius unit (max-projection tree, or a 26-step sqrt
// pipeline for two or fewer sides), the job register, one queue slot, the
// 27-stage bit-per-stage dividers and the output register. Registers are to be
// written through cfg_valid/cfg_ready while no hit is in flight; the block
// itself does not enforce this. Unknown indexes are ignored.
module calo_layers_from_edge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_x,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_y,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_z,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [clfe_pkg::OUT_W-1:0]   layers_from_edge,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clfe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clfe_pkg::CFG_W-1:0]          cfg_data
);
    import clfe_pkg::*;

    cfg_t      cfg_reg;
    logic      in_full;
    logic      q_full;
    logic      q_push;
    q_entry_t  q_in;
    logic      q_pop;
    logic      q_valid;
    q_entry_t  q_head;

    assign cfg_ready = 1'b1;
    assign full      = in_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_z                <= '0;
            cfg_reg.barrel_outer_radius    <= '0;
            cfg_reg.endcap_outer_radius    <= '0;
            cfg_reg.endcap_outer_z         <= '0;
            cfg_reg.barrel_outer_z         <= '0;
            cfg_reg.barrel_layer_thickness <= CFG_W'(1);
            cfg_reg.endcap_layer_thickness <= CFG_W'(1);
            cfg_reg.max_rear_layers        <= MRL_W'(4000);
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPLIT_Z:         cfg_reg.split_z                <= cfg_data;
                CFG_BARREL_OUTER_R:  cfg_reg.barrel_outer_radius    <= cfg_data;
                CFG_ENDCAP_OUTER_R:  cfg_reg.endcap_outer_radius    <= cfg_data;
                CFG_ENDCAP_OUTER_Z:  cfg_reg.endcap_outer_z         <= cfg_data;
                CFG_BARREL_OUTER_Z:  cfg_reg.barrel_outer_z         <= cfg_data;
                CFG_BARREL_THICK:    cfg_reg.barrel_layer_thickness <= cfg_data;
                CFG_ENDCAP_THICK:    cfg_reg.endcap_layer_thickness <= cfg_data;
                CFG_MAX_REAR_LAYERS: cfg_reg.max_rear_layers        <= cfg_data[MRL_W-1:0];
                default: ;
            endcase
        end
    end

    clfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push && !in_full),
        .hit_x    (hit_x),
        .hit_y    (hit_y),
        .hit_z    (hit_z),
        .in_full  (in_full),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    clfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    clfe_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .max_rear_layers  (cfg_reg.max_rear_layers),
        .empty            (empty),
        .pop              (pop),
        .layers_from_edge (layers_from_edge)
    );

endmodule

// File: src/clfe_radius.sv
// Barrel and endcap polygon radius, stalled by en.
// Max-projection tree for polygons, digit-serial pipelined sqrt for round shapes.
// Depends on clfe_pkg.
module clfe_radius (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [clfe_pkg::COORD_W-1:0] x,
    input  logic signed [clfe_pkg::COORD_W-1:0] y,
    output logic [clfe_pkg::RAD_W-1:0]          rb,
    output logic [clfe_pkg::RAD_W-1:0]          re
);
    import clfe_pkg::*;

    logic [RAD_W-1:0] rad [2];
    logic [RAD_W-1:0] sq_res;

    // Euclidean radius: floor(sqrt((x*x + y*y) << 16)), one result bit per stage
    if (ANY_SQRT) begin : g_sqrt
        logic [35:0] xx_reg;
        logic [35:0] yy_reg;
        logic [51:0] v_reg [SQRT_STEPS+1];
        logic [51:0] r_reg [SQRT_STEPS+1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xx_reg   <= 36'(x * x);
                yy_reg   <= 36'(y * y);
                v_reg[0] <= {xx_reg + yy_reg, 16'h0000};
                r_reg[0] <= '0;
            end
        end

        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
            localparam logic [51:0] BIT_K = 52'(1) << (2 * (SQRT_STEPS - 1 - k));
            logic [51:0] trial;
            assign trial = r_reg[k] + BIT_K;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (v_reg[k] >= trial)
                    begin
                        v_reg[k+1] <= v_reg[k] - trial;
                        r_reg[k+1] <= (r_reg[k] >> 1) + BIT_K;
                    end
                    else
                    begin
                        v_reg[k+1] <= v_reg[k];
                        r_reg[k+1] <= r_reg[k] >> 1;
                    end
                end
            end
        end

        assign sq_res = r_reg[SQRT_STEPS][RAD_W-1:0];
    end
    else begin : g_no_sqrt
        assign sq_res = '0;
    end

    for (genvar p = 0; p < 2; p++) begin : g_shape
        if (poly_sides(p) > 2) begin : g_poly
            logic signed [34:0] px_reg [MAX_SIDES];
            logic signed [34:0] py_reg [MAX_SIDES];
            logic [35:0]        node_reg [TREE_NODES];
            logic [RAD_W-1:0]   poly_out;

            // Projection onto each side normal; missing sides sit at zero
            for (genvar i = 0; i < MAX_SIDES; i++) begin : g_side
                localparam longint unsigned ANG =
                    (p == 0) ? angle_barrel(i) : angle_endcap(i);
                localparam logic signed [16:0] COS_I = norm_val(ANG, 1'b0);
                localparam logic signed [16:0] SIN_I = norm_val(ANG, 1'b1);
                logic signed [35:0] proj;
                assign proj = 36'(px_reg[i]) + 36'(py_reg[i]);
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        if (i < poly_sides(p))
                        begin
                            px_reg[i] <= x * COS_I;
                            py_reg[i] <= y * SIN_I;
                        end
                        else
                        begin
                            px_reg[i] <= '0;
                            py_reg[i] <= '0;
                        end
                        node_reg[MAX_SIDES-1+i] <= (proj > 0) ? 36'(proj) : '0;
                    end
                end
            end

            // Registered max tree, one level per cycle while en is high
            for (genvar n = 0; n < MAX_SIDES - 1; n++) begin : g_node
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        node_reg[n] <= (node_reg[2*n+1] > node_reg[2*n+2]) ?
                                       node_reg[2*n+1] : node_reg[2*n+2];
                    end
                end
            end

            assign poly_out = node_reg[0][RAD_W+6:7];

            // Align with the sqrt path when that one sets the latency
            if (RAD_LAT > POLY_LAT) begin : g_pad
                logic [RAD_W-1:0] pad_reg [RAD_LAT-POLY_LAT];
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        pad_reg[0] <= poly_out;
                        for (int j = 1; j < RAD_LAT - POLY_LAT; j++)
                        begin
                            pad_reg[j] <= pad_reg[j-1];
                        end
                    end
                end
                assign rad[p] = pad_reg[RAD_LAT-POLY_LAT-1];
            end
            else begin : g_nopad
                assign rad[p] = poly_out;
            end
        end
        else begin : g_round
            assign rad[p] = sq_res;
        end
    end

    assign rb = rad[0];
    assign re = rad[1];

endmodule

// File: src/clfe_front.sv
// Front end: accepts hits, computes radii, classifies barrel/endcap and
// forms the three division jobs. Depends on clfe_pkg and clfe_radius.
module clfe_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_x,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_y,
    input  logic signed [clfe_pkg::COORD_W-1:0] hit_z,
    output logic                               in_full,
    input  clfe_pkg::cfg_t                     cfg,
    input  logic                               q_full,
    output logic                               q_push,
    output clfe_pkg::q_entry_t                 q_data
);
    import clfe_pkg::*;

    logic                 en;
    logic                 fv_reg [FRONT_LAT];
    logic [COORD_W-1:0]   az_reg [RAD_LAT];
    logic [COORD_W-1:0]   az_in;
    logic [RAD_W-1:0]     rb;
    logic [RAD_W-1:0]     re;
    logic [CFG_W-1:0]     tb;
    logic [CFG_W-1:0]     te;
    logic [COORD_W-1:0]   az;
    q_entry_t             entry_next;
    q_entry_t             entry_reg;

    // Whole front advances unless its finished hit cannot enter the queue
    assign en      = !(fv_reg[FRONT_LAT-1] && q_full);
    assign in_full = !en;
    assign q_push  = fv_reg[FRONT_LAT-1] && en;
    assign q_data  = entry_reg;

    assign az_in = hit_z[COORD_W-1] ? COORD_W'(-hit_z) : COORD_W'(hit_z);

    clfe_radius u_radius (
        .clk (clk),
        .en  (en),
        .x   (hit_x),
        .y   (hit_y),
        .rb  (rb),
        .re  (re)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT_LAT; k++)
            begin
                fv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            fv_reg[0] <= in_valid;
            for (int k = 1; k < FRONT_LAT; k++)
            begin
                fv_reg[k] <= fv_reg[k-1];
            end
        end
    end

    // |z| travels alongside the radius unit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg[0] <= az_in;
            for (int k = 1; k < RAD_LAT; k++)
            begin
                az_reg[k] <= az_reg[k-1];
            end
        end
    end

    // Classification and division job setup; zero thickness acts as one
    always_comb
    begin
        az = az_reg[RAD_LAT-1];
        tb = (cfg.barrel_layer_thickness == '0) ? CFG_W'(1) : cfg.barrel_layer_thickness;
        te = (cfg.endcap_layer_thickness == '0) ? CFG_W'(1) : cfg.endcap_layer_thickness;
        entry_next.barrel = az < {1'b0, cfg.split_z};
        entry_next.num_b  = $signed({3'b000, cfg.endcap_outer_radius, 8'h00})
                          - $signed({2'b00, re});
        entry_next.den_b  = {te, 4'h0};
        if (entry_next.barrel)
        begin
            entry_next.num_a = $signed({3'b000, cfg.barrel_outer_radius, 8'h00})
                             - $signed({2'b00, rb});
            entry_next.den_a = {tb, 4'h0};
            entry_next.num_c = $signed({7'b0, cfg.barrel_outer_z, 4'h0})
                             - $signed({6'b0, az, 4'h0});
            entry_next.den_c = {4'h0, tb};
        end
        else
        begin
            entry_next.num_a = entry_next.num_b;
            entry_next.den_a = entry_next.den_b;
            entry_next.num_c = $signed({7'b0, cfg.endcap_outer_z, 4'h0})
                             - $signed({6'b0, az, 4'h0});
            entry_next.den_c = {4'h0, te};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: src/clfe_queue.sv
// Short FIFO of classified hits between front and back.
// Depends on clfe_pkg.
module clfe_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clfe_pkg::q_entry_t   push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output clfe_pkg::q_entry_t   head
);
    import clfe_pkg::*;

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_pop;

    assign full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/clfe_div.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// Depends on clfe_pkg.
module clfe_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [clfe_pkg::NUM_W-1:0] num,
    input  logic [clfe_pkg::DEN_W-1:0]        den,
    output logic signed [clfe_pkg::NUM_W-1:0] quo
);
    import clfe_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [MAG_W-1:0] mag_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic             neg_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DEN_W-1:0] rem_p;
        logic [MAG_W-1:0] mag_p;
        logic [DEN_W-1:0] den_p;
        logic             neg_p;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_p = '0;
            assign mag_p = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            assign den_p = den;
            assign neg_p = num[NUM_W-1];
        end
        else begin : g_next
            assign rem_p = rem_reg[k-1];
            assign mag_p = mag_reg[k-1];
            assign den_p = den_reg[k-1];
            assign neg_p = neg_reg[k-1];
        end

        // Shift in the next dividend bit, subtract if it fits
        assign trial = {rem_p, mag_p[MAG_W-1]};
        assign ge    = trial >= {1'b0, den_p};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
                mag_reg[k] <= {mag_p[MAG_W-2:0], ge};
                den_reg[k] <= den_p;
                neg_reg[k] <= neg_p;
            end
        end
    end

    assign quo = neg_reg[DIV_STAGES-1] ? -$signed({1'b0, mag_reg[DIV_STAGES-1]})
                                       :  $signed({1'b0, mag_reg[DIV_STAGES-1]});

endmodule

// File: src/clfe_back.sv
// Back end: three dividers, rear/radial selection, whole-layer truncation and
// saturation into the output register. Depends on clfe_pkg and clfe_div.
module clfe_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  clfe_pkg::q_entry_t                q_head,
    output logic                              q_pop,
    input  logic [clfe_pkg::MRL_W-1:0]        max_rear_layers,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [clfe_pkg::OUT_W-1:0] layers_from_edge
);
    import clfe_pkg::*;

    logic                     en;
    logic                     bv_reg [BACK_LAT];
    logic                     bar_reg [DIV_STAGES];
    logic signed [NUM_W-1:0]  qa;
    logic signed [NUM_W-1:0]  qb;
    logic signed [NUM_W-1:0]  qc;
    logic signed [NUM_W-1:0]  rear;
    logic signed [NUM_W-1:0]  res;
    logic [NUM_W-1:0]         res_mag;
    logic signed [NUM_W-1:0]  whole;
    logic                     have_rear;
    logic signed [OUT_W-1:0]  layers_next;
    logic signed [OUT_W-1:0]  layers_reg;

    // Advance while the output register is free or being taken
    assign en    = !bv_reg[BACK_LAT-1] || pop;
    assign q_pop = en && q_valid;
    assign empty = !bv_reg[BACK_LAT-1];
    assign layers_from_edge = layers_reg;

    clfe_div u_div_a (.clk(clk), .en(en), .num(q_head.num_a), .den(q_head.den_a), .quo(qa));
    clfe_div u_div_b (.clk(clk), .en(en), .num(q_head.num_b), .den(q_head.den_b), .quo(qb));
    clfe_div u_div_c (.clk(clk), .en(en), .num(q_head.num_c), .den(q_head.den_c), .quo(qc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BACK_LAT; k++)
            begin
                bv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            bv_reg[0] <= q_valid;
            for (int k = 1; k < BACK_LAT; k++)
            begin
                bv_reg[k] <= bv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bar_reg[0] <= q_head.barrel;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                bar_reg[k] <= bar_reg[k-1];
            end
            layers_reg <= layers_next;
        end
    end

    // qa: radial, qb: endcap radial, qc: rear candidate
    always_comb
    begin
        if (bar_reg[DIV_STAGES-1])
        begin
            // Overlap rule applies only while the barrel rear distance is short
            have_rear = qc < $signed({{(NUM_W-MRL_W){1'b0}}, max_rear_layers});
            rear      = (qc > qb) ? qc : qb;
        end
        else
        begin
            have_rear = 1'b1;
            rear      = qc;
        end
        res     = (have_rear && (rear < qa)) ? rear : qa;
        res_mag = res[NUM_W-1] ? NUM_W'(-res) : NUM_W'(res);
        whole   = res[NUM_W-1] ? -$signed(res_mag >> 4) : $signed(res_mag >> 4);
        if (whole > $signed(NUM_W'(32767)))
        begin
            layers_next = 16'sh7FFF;
        end
        else if (whole < -$signed(NUM_W'(32768)))
        begin
            layers_next = -16'sh8000;
        end
        else
        begin
            layers_next = whole[OUT_W-1:0];
        end
    end

endmodule
